// File: src/mfdl_pkg.sv
// Shared types, constants and arithmetic helpers of the multitap feedback delay line.
package mfdl_pkg;

	// Store depth; a power of two, so address and delay wrap by truncation.
	localparam int BUFFER_DEPTH = 65536;
	localparam int MAX_TAPS     = 4;

	localparam int AW     = $clog2(BUFFER_DEPTH);
	localparam int SW     = 16;
	localparam int GW     = 16;
	localparam int PW     = SW + GW;
	localparam int ACC_W  = PW + 1 + $clog2(MAX_TAPS + 1);
	localparam int TCW    = 3;
	localparam int TI_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int REG_W  = 48;
	localparam int IDX_W  = 3;
	localparam int FRAC_W = 14;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_TAP_COUNT = 3'd0;
	localparam logic [IDX_W-1:0] REG_TAP0      = 3'd1;

	typedef struct packed {
		logic        [15:0]   delay;
		logic signed [GW-1:0] g_out;
		logic signed [GW-1:0] g_fb;
	} tap_cfg_t;

	// Control from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic                 load;
		logic signed [SW-1:0] x;
		logic                 rd_vld_s1;
		logic signed [GW-1:0] g_out;
		logic signed [GW-1:0] g_fb;
	} mac_ctrl_t;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_RUN   = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	// Reduce a delay to the store size (depth is a power of two).
	function automatic logic [AW-1:0] delay_wrap(input logic [15:0] d);
		delay_wrap = AW'(d);
	endfunction

	// Round a Q7.29 sum to Q1.15 (halves toward plus infinity) and saturate.
	function automatic logic signed [SW-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W:0]        sum;
		logic signed [ACC_W-FRAC_W:0] sh;
		sum = {acc[ACC_W-1], acc} + (ACC_W+1)'(1 << (FRAC_W - 1));
		sh  = sum[ACC_W:FRAC_W];
		if (sh > (ACC_W-FRAC_W+1)'(32767))
			round_sat = 16'sh7FFF;
		else if (sh < -(ACC_W-FRAC_W+1)'(32768))
			round_sat = 16'sh8000;
		else
			round_sat = sh[SW-1:0];
	endfunction

endpackage

// File: src/mfdl_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module mfdl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/mfdl_cfg.sv
// Configuration registers: tap count and per-tap delay and gains.
module mfdl_cfg
	import mfdl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [REG_W-1:0] wr_data,
	output logic [TCW-1:0]   n_taps,
	output tap_cfg_t         taps [MAX_TAPS]
);

	logic [TCW-1:0] tap_count_q;
	tap_cfg_t       taps_q [MAX_TAPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= '0;
			for (int i = 0; i < MAX_TAPS; i++)
				taps_q[i] <= '0;
		end else if (wr_en) begin
			if (wr_index == REG_TAP_COUNT)
				tap_count_q <= wr_data[TCW-1:0];
			for (int i = 0; i < MAX_TAPS; i++) begin
				if (wr_index == IDX_W'(REG_TAP0 + i)) begin
					taps_q[i].delay <= wr_data[15:0];
					taps_q[i].g_out <= wr_data[31:16];
					taps_q[i].g_fb  <= wr_data[47:32];
				end
			end
		end
	end

	// clamp the tap count to the taps built
	assign n_taps = (tap_count_q > TCW'(MAX_TAPS)) ? TCW'(MAX_TAPS) : tap_count_q;

	always_comb begin
		for (int i = 0; i < MAX_TAPS; i++)
			taps[i] = taps_q[i];
	end

endmodule

// File: src/mfdl_mac.sv
// Multiply-accumulate unit: one tap product pair per cycle into two sums.
module mfdl_mac
	import mfdl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  mac_ctrl_t            ctrl,
	input  logic signed [SW-1:0] rdata,
	output logic                 busy,
	output logic signed [SW-1:0] fb_word,
	output logic signed [SW-1:0] out_word
);

	logic                    v_s2;
	logic signed [PW-1:0]    prod_fb_s2;
	logic signed [PW-1:0]    prod_out_s2;
	logic signed [ACC_W-1:0] acc_fb_q;
	logic signed [ACC_W-1:0] acc_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= ctrl.rd_vld_s1;
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_vld_s1) begin
			prod_fb_s2  <= rdata * ctrl.g_fb;
			prod_out_s2 <= rdata * ctrl.g_out;
		end
		if (ctrl.load) begin
			// dry sample moved to Q7.29
			acc_fb_q  <= ACC_W'(ctrl.x) <<< FRAC_W;
			acc_out_q <= ACC_W'(ctrl.x) <<< FRAC_W;
		end else if (v_s2) begin
			acc_fb_q  <= acc_fb_q + ACC_W'(prod_fb_s2);
			acc_out_q <= acc_out_q + ACC_W'(prod_out_s2);
		end
	end

	assign busy     = v_s2;
	assign fb_word  = round_sat(acc_fb_q);
	assign out_word = round_sat(acc_out_q);

endmodule

// File: src/multitap_feedback_delay_line_unit.sv
// Top level: sequencer, delay store and output register of the multitap feedback delay line.
// A new input word is taken only when the previous one has finished; while the output is taken,
// the single read port of the delay store serves one tap per cycle, then the feedback sum is
// written back.
// Reset: asynchronous, active low; control registers clear at once, then a clearing pass
// writes zeros to all 65536 store entries with s_axis_tready low.
// Configuration writes are taken at any time, including during the clearing pass.
module multitap_feedback_delay_line_unit
	import mfdl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// configuration write port
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [REG_W-1:0] wr_data,
	// input stream
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [15:0]      s_axis_tdata,   // [15:0] sample_in
	// output stream
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [15:0]      m_axis_tdata    // [15:0] sample_out
);

	state_t         state_q;
	logic [AW-1:0]  clr_addr_q;
	logic [AW-1:0]  wp_q;
	logic [TCW-1:0] tap_idx_q;
	logic [TCW-1:0] n_q;
	logic [TI_W-1:0] tap_s1;
	logic           rd_vld_s1;
	logic           out_valid_q;
	logic [15:0]    out_data_q;

	logic [TCW-1:0] n_taps;
	tap_cfg_t       taps [MAX_TAPS];

	logic           in_fire;
	logic           out_fire;
	logic           fin_go;
	logic           issue;
	logic [AW-1:0]  d_wrap;
	logic [AW:0]    diff;
	logic [AW-1:0]  raddr;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [SW-1:0]  ram_wdata;
	logic [SW-1:0]  ram_rdata;

	mac_ctrl_t            mac_ctrl;
	logic                 mac_busy;
	logic signed [SW-1:0] fb_word;
	logic signed [SW-1:0] out_word;

	mfdl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.n_taps  (n_taps),
		.taps    (taps)
	);

	// Handshakes. Take an input only when idle; the output register lets the
	// next word start while the previous result still waits downstream.
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_fire      = m_axis_tvalid && m_axis_tready;
	// finish only when the output register is free or empties this cycle
	assign fin_go        = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);
	assign issue         = (state_q == ST_RUN) && (tap_idx_q < n_q);

	// Read address: write pointer minus tap delay, wrapped into the store.
	assign d_wrap = delay_wrap(taps[tap_idx_q[TI_W-1:0]].delay);
	assign diff   = {1'b0, wp_q} - {1'b0, d_wrap};
	assign raddr  = diff[AW] ? AW'(diff + (AW+1)'(BUFFER_DEPTH)) : diff[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			wp_q        <= '0;
			tap_idx_q   <= '0;
			n_q         <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (out_fire)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					// sweep zeros through the store, one entry per cycle
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(BUFFER_DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_fire) begin
						// advance the write pointer before the taps read
						wp_q      <= (wp_q == AW'(BUFFER_DEPTH - 1)) ? '0 : wp_q + 1'b1;
						tap_idx_q <= '0;
						n_q       <= n_taps;
						state_q   <= ST_RUN;
					end
				end
				ST_RUN: begin
					// issue one tap read per cycle
					if (issue)
						tap_idx_q <= tap_idx_q + 1'b1;
					else
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					// wait until the last product lands in the sums
					if (!rd_vld_s1 && !mac_busy)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers: sample held for the MAC load, tap index follows the read.
	logic signed [SW-1:0] x_q;

	always_ff @(posedge clk) begin
		if (in_fire)
			x_q <= s_axis_tdata;
		if (issue)
			tap_s1 <= tap_idx_q[TI_W-1:0];
		if (fin_go)
			out_data_q <= out_word;
	end

	// The MAC loads the dry sample in the cycle after accept, before any product arrives.
	logic load_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			load_q <= 1'b0;
		else
			load_q <= in_fire;
	end

	always_comb begin
		mac_ctrl.load      = load_q;
		mac_ctrl.x         = x_q;
		mac_ctrl.rd_vld_s1 = rd_vld_s1;
		mac_ctrl.g_out     = taps[tap_s1].g_out;
		mac_ctrl.g_fb      = taps[tap_s1].g_fb;
	end

	mfdl_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (mac_ctrl),
		.rdata   (ram_rdata),
		.busy    (mac_busy),
		.fb_word (fb_word),
		.out_word(out_word)
	);

	// Store write: zeros during the clearing pass, else the feedback sum at the
	// write pointer. Reads of this word's taps are all done before the write.
	assign ram_we    = (state_q == ST_CLEAR) || fin_go;
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q : wp_q;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : fb_word;

	mfdl_ram #(
		.WIDTH(SW),
		.DEPTH(BUFFER_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// File: src/mfdl_checker.sv
// Port-level assertions for the multitap feedback delay line, bound to the top level.
module mfdl_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [15:0]      m_axis_tdata
);

	// one word at a time: no accept in the cycle right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while a word is in flight");

	// no early result: the output valid must not rise at the delay checked after an accept
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |-> ##2 !$rose(m_axis_tvalid))
		else $error("result appeared too early");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled output word changed or dropped");

	// not ready right out of reset: the store is being cleared
	a_clear_after_reset: assert property (@(posedge clk)
		!arst_n |=> !s_axis_tready)
		else $error("ready during store clearing");

endmodule

bind multitap_feedback_delay_line_unit mfdl_checker u_mfdl_checker (.*);
